>>> sv/sipf_pkg.sv
// ----------------------------------------------------------------------------
// sipf_pkg
// Shared widths, constants and helpers for the servo instruction packet
// framer and its port checker.
// ----------------------------------------------------------------------------
package sipf_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int LEN_W    = 16;
    localparam int CRC_W    = 16;
    localparam int S_DATA_W = 32;
    localparam int STEP_W   = 4;

    // Largest parameter count a packet may carry; larger counts saturate
    localparam logic [COUNT_W-1:0] MAX_PARAMS = COUNT_W'(1024);

    localparam logic [7:0]  SERVO_ID_RST = 8'h01;
    localparam logic [15:0] CRC_POLY     = 16'h8005;
    localparam logic [15:0] LEN_EXTRA    = 16'd3;

    // Kind of an input beat (carried in s_tuser)
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_PARAM = 1'b1
    } func_t;

    // Sequence positions within one input item
    localparam logic [STEP_W-1:0] STEP_HDR0   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HDR1   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_HDR2   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_HDR3   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ID     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LEN_LO = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LEN_HI = 4'd6;
    localparam logic [STEP_W-1:0] STEP_INSTR  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CRC_LO = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CRC_HI = 4'd9;

    // CRC-16, poly 0x8005, MSB first, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> sv/servo_instruction_packet_framer_unit.sv
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer_unit
// Builds servo bus instruction packets (header, id, length, instruction,
// parameters, CRC-16) one byte per output beat.
// ----------------------------------------------------------------------------
// One output beat is produced per clock while an item is held and m_tready
// is high. A start beat gives ten output beats at count zero, eight otherwise;
// a parameter beat yields one, or three when it closes the packet. The input
// side is held by a one-item register that frees on the cycle its final byte
// moves to the output register, so a new beat is taken in that same cycle;
// the input rate is therefore set by the output byte stream. Counts above
// MAX_PARAMS saturate. A parameter beat with no open packet gives one beat
// with tuser (error) set and data zero. servo_id is written through the cfg
// channel, which is always ready, and must only change while the block idles.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: servo_id
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [7:0]                     cfg_data,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] instruction, [18:8] param_count, [26:19] data_byte, [31:27] zero
    input  logic [sipf_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] func
    input  logic                           s_tuser,
    // Output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] out_byte
    output logic [7:0]                     m_tdata,
    // last
    output logic                           m_tlast,
    // [0] error
    output logic                           m_tuser
);
    import sipf_pkg::*;

    // Held input item
    logic                 hold_valid_reg;
    func_t                func_reg;
    logic [7:0]           instr_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [7:0]           data_reg;

    // Packet state
    logic [STEP_W-1:0]    step_reg,   step_next;
    logic [CRC_W-1:0]     crc_reg,    crc_next;
    logic [COUNT_W-1:0]   left_reg,   left_next;
    logic                 open_reg,   open_next;
    logic [7:0]           servo_id_reg;

    // Output register
    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;
    logic                 m_last_reg;
    logic                 m_err_reg;

    // Per-beat combinational results
    logic                 advance;
    logic                 item_done;
    logic [COUNT_W-1:0]   count_sat;
    logic [LEN_W-1:0]     len;
    logic                 param_err;
    logic [7:0]           byte_out;
    logic                 byte_last;
    logic                 byte_framed;
    logic [CRC_W-1:0]     crc_in;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_err_reg;

    // Produce a byte when an item is held and the output slot is free
    assign advance   = hold_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !hold_valid_reg || (advance && item_done);

    // Saturate the count and form the length field
    assign count_sat = (count_reg > MAX_PARAMS) ? MAX_PARAMS : count_reg;
    assign len       = LEN_W'(count_sat) + LEN_EXTRA;
    assign param_err = (func_reg == FUNC_PARAM) && (step_reg == STEP_HDR0)
                       && (!open_reg || left_reg == '0);

    // Select the byte for this step
    always_comb
    begin
        byte_out    = 8'h00;
        byte_last   = 1'b0;
        byte_framed = 1'b1;
        case (step_reg)
            STEP_HDR0:
            begin
                if (func_reg == FUNC_PARAM)
                begin
                    byte_out    = param_err ? 8'h00 : data_reg;
                    byte_framed = !param_err;
                end
                else
                begin
                    byte_out = 8'hFF;
                end
            end
            STEP_HDR1:   byte_out = 8'hFF;
            STEP_HDR2:   byte_out = 8'hFD;
            STEP_HDR3:   byte_out = 8'h00;
            STEP_ID:     byte_out = servo_id_reg;
            STEP_LEN_LO: byte_out = len[7:0];
            STEP_LEN_HI: byte_out = len[15:8];
            STEP_INSTR:  byte_out = instr_reg;
            STEP_CRC_LO:
            begin
                byte_out    = crc_reg[7:0];
                byte_framed = 1'b0;
            end
            STEP_CRC_HI:
            begin
                byte_out    = crc_reg[15:8];
                byte_last   = 1'b1;
                byte_framed = 1'b0;
            end
            default:
            begin
                byte_out    = 8'h00;
                byte_framed = 1'b0;
            end
        endcase
    end

    // Advance the sequence, the CRC and the packet state
    always_comb
    begin
        crc_in    = (func_reg == FUNC_START && step_reg == STEP_HDR0) ? '0 : crc_reg;
        crc_next  = byte_framed ? crc_byte(crc_in, byte_out) : crc_reg;
        step_next = step_reg + STEP_W'(1);
        left_next = left_reg;
        open_next = open_reg;
        item_done = 1'b0;
        case (step_reg)
            STEP_HDR0:
            begin
                if (func_reg == FUNC_PARAM)
                begin
                    if (param_err)
                    begin
                        item_done = 1'b1;
                        step_next = STEP_HDR0;
                    end
                    else
                    begin
                        left_next = left_reg - COUNT_W'(1);
                        if (left_reg == COUNT_W'(1))
                        begin
                            step_next = STEP_CRC_LO;
                        end
                        else
                        begin
                            item_done = 1'b1;
                            step_next = STEP_HDR0;
                        end
                    end
                end
            end
            STEP_INSTR:
            begin
                if (count_sat == '0)
                begin
                    step_next = STEP_CRC_LO;
                end
                else
                begin
                    item_done = 1'b1;
                    step_next = STEP_HDR0;
                    left_next = count_sat;
                    open_next = 1'b1;
                end
            end
            STEP_CRC_HI:
            begin
                item_done = 1'b1;
                step_next = STEP_HDR0;
                crc_next  = '0;
                left_next = '0;
                open_next = 1'b0;
            end
            default:
            begin
                step_next = step_reg + STEP_W'(1);
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            step_reg       <= STEP_HDR0;
            crc_reg        <= '0;
            left_reg       <= '0;
            open_reg       <= 1'b0;
            servo_id_reg   <= SERVO_ID_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                servo_id_reg <= cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance && item_done)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                m_valid_reg <= 1'b1;
                step_reg    <= step_next;
                crc_reg     <= crc_next;
                left_reg    <= left_next;
                open_reg    <= open_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg  <= func_t'(s_tuser);
            instr_reg <= s_tdata[7:0];
            count_reg <= s_tdata[18:8];
            data_reg  <= s_tdata[26:19];
        end
        if (advance)
        begin
            m_data_reg <= byte_out;
            m_last_reg <= byte_last;
            m_err_reg  <= param_err;
        end
    end

endmodule

>>> sv/sipf_checker.sv
// ----------------------------------------------------------------------------
// sipf_checker
// Port-level checks for the servo instruction packet framer, bound to the
// top level.
// ----------------------------------------------------------------------------
module sipf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [7:0]                     cfg_data,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sipf_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [7:0]                     m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);
    import sipf_pkg::*;

    // An error beat carries a zero byte and never closes a packet
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 8'h00 && !m_tlast)
        else $error("error beat with data or last set");

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled output beat changed");

    // Hold a waiting input beat until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting input beat changed");

    // Take every configuration write at once, with known data
    a_cfg_take: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
        else $error("configuration write not taken or unknown");

    // Nothing is presented on the first cycle out of reset
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind servo_instruction_packet_framer_unit sipf_checker u_sipf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
);

>>> tb/servo_instruction_packet_framer_unit_tb.sv
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer_unit_tb
// Drives start and parameter beats into the packet framer and compares every
// output beat against a behavioural packet builder kept in the bench (header,
// id, length, instruction, parameters, CRC-16). Directed packets cover the
// edge cases; random packet traffic then runs under several idle/stall mixes.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sipf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [7:0]  HDR_SYNC       = 8'hFF;
    localparam logic [7:0]  HDR_MARK       = 8'hFD;
    localparam logic [7:0]  HDR_RSVD       = 8'h00;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } out_beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // [7:0] instruction, [18:8] param_count, [26:19] data_byte, [31:27] zero
    logic [S_DATA_W-1:0] s_tdata = '0;
    // [0] func
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [7:0] out_byte
    logic [7:0]  m_tdata;
    logic        m_tlast;
    // [0] error
    logic        m_tuser;

    // Packet builder state
    logic [7:0]  id_model = SERVO_ID_RST;
    logic [15:0] crc_model = '0;
    int unsigned params_due = 0;
    logic        frame_open = 1'b0;
    out_beat_t   framed_q[$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;

    servo_instruction_packet_framer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // Packet builder
    // ------------------------------------------------------------------------

    // Shift one byte through the CRC register a bit at a time, MSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic push_framed(input logic [7:0] b);
        crc_model = crc16_next(crc_model, b);
        framed_q.push_back('{data: b, last: 1'b0, err: 1'b0});
    endtask

    // Append the CRC, low byte first, and close the packet
    task automatic close_frame();
        framed_q.push_back('{data: crc_model[7:0], last: 1'b0, err: 1'b0});
        framed_q.push_back('{data: crc_model[15:8], last: 1'b1, err: 1'b0});
        frame_open = 1'b0;
        params_due = 0;
        crc_model  = '0;
    endtask

    task automatic predict_start(input logic [7:0] instr, input logic [10:0] count);
        int unsigned n;
        logic [15:0] len;
        n   = 32'((count > MAX_PARAMS) ? MAX_PARAMS : count);
        len = 16'(n) + LEN_EXTRA;
        crc_model = '0;
        push_framed(HDR_SYNC);
        push_framed(HDR_SYNC);
        push_framed(HDR_MARK);
        push_framed(HDR_RSVD);
        push_framed(id_model);
        push_framed(len[7:0]);
        push_framed(len[15:8]);
        push_framed(instr);
        if (n == 0)
        begin
            close_frame();
        end
        else
        begin
            params_due = n;
            frame_open = 1'b1;
        end
    endtask

    task automatic predict_param(input logic [7:0] b);
        if (!frame_open || params_due == 0)
        begin
            framed_q.push_back('{data: 8'h00, last: 1'b0, err: 1'b1});
        end
        else
        begin
            push_framed(b);
            params_due--;
            if (params_due == 0)
            begin
                close_frame();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one beat, hold it until taken, then update the packet builder
    task automatic send_item(input func_t kind, input logic [7:0] instr,
                             input logic [10:0] count, input logic [7:0] b);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, b, count, instr};
        do @(posedge clk); while (!s_tready);
        if (kind == FUNC_START)
        begin
            predict_start(instr, count);
        end
        else
        begin
            predict_param(b);
        end
    endtask

    // Unused fields carry random junk
    task automatic send_start(input logic [7:0] instr, input logic [10:0] count);
        send_item(FUNC_START, instr, count, 8'($urandom_range(255)));
    endtask

    task automatic send_param(input logic [7:0] b);
        send_item(FUNC_PARAM, 8'($urandom_range(255)), 11'($urandom_range(2047)), b);
    endtask

    // Drop valid and wait for every expected beat to arrive
    task automatic settle();
        s_tvalid <= 1'b0;
        while (framed_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_servo_id(input logic [7:0] id);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        id_model = id;
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Stray parameters straight after reset, then an empty packet at reset id
    task automatic test_stray_and_empty();
        send_param(8'hFF);
        send_item(FUNC_PARAM, 8'hFF, 11'h7FF, 8'h00);
        send_start(8'h00, 11'd0);
        settle();
    endtask

    // One-parameter packet at the top id, then a stray after it closes
    task automatic test_single_param();
        write_servo_id(8'hFF);
        send_start(8'hFF, 11'd1);
        send_param(8'h00);
        send_param(8'hFF);
        settle();
    endtask

    // Abandon an open packet with a new start, then finish the new one
    task automatic test_abandon();
        write_servo_id(8'h00);
        send_start(8'h55, 11'd3);
        send_param(8'hFF);
        send_start(8'hAA, 11'd2);
        send_param(8'h0F);
        send_param(8'hF0);
        settle();
    endtask

    // Length field at and beyond the saturation point
    task automatic test_saturated_length();
        send_start(8'h03, 11'h7FF);
        send_param(8'($urandom_range(255)));
        send_start(8'h01, MAX_PARAMS);
        send_start(8'h02, MAX_PARAMS + 11'd1);
        send_start(8'h04, 11'd0);
        settle();
    endtask

    // Mostly well-formed packets, with truncated, oversized and stray beats
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned cnt;
        int unsigned upto;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                cnt = ($urandom_range(19) == 0) ? $urandom_range(7, 24) : $urandom_range(6);
                upto = cnt;
            end
            else if (pick < 82)
            begin
                cnt  = $urandom_range(2, 8);
                upto = $urandom_range(cnt - 1);
            end
            else if (pick < 90)
            begin
                cnt  = $urandom_range(2047);
                upto = $urandom_range(3);
            end
            else
            begin
                cnt  = 0;
                upto = $urandom_range(1, 2);
            end
            if (pick < 90)
            begin
                send_start(8'($urandom_range(255)), 11'(cnt));
                sent++;
            end
            repeat (upto)
            begin
                send_param(8'($urandom_range(255)));
            end
            sent += upto;
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Output checker and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : sink
        out_beat_t exp_beat;
        if (m_tvalid && m_tready)
        begin
            if (framed_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected beat, expected none,", $time,
                         " actual data %h last %b err %b", m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                exp_beat = framed_q.pop_front();
                if (m_tdata !== exp_beat.data || m_tlast !== exp_beat.last
                    || m_tuser !== exp_beat.err)
                begin
                    fail_count++;
                    $display("%0t: beat mismatch, expected data %h last %b err %b,",
                             $time, exp_beat.data, exp_beat.last, exp_beat.err,
                             " actual data %h last %b err %b",
                             m_tdata, m_tlast, m_tuser);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Stop a hung run: count cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] phase_id[4];
        phase_id[0] = 8'h7E;
        phase_id[1] = 8'($urandom_range(255));
        phase_id[2] = 8'h80;
        phase_id[3] = 8'hFE;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_stray_and_empty();
        test_single_param();
        test_abandon();
        test_saturated_length();

        // Random traffic under each idle/stall mix, new id per phase
        set_idling(0, 0);
        write_servo_id(phase_id[0]);
        test_random_traffic(21);
        set_idling(51, 0);
        write_servo_id(phase_id[1]);
        test_random_traffic(21);
        set_idling(0, 51);
        write_servo_id(phase_id[2]);
        test_random_traffic(21);
        set_idling(35, 35);
        write_servo_id(phase_id[3]);
        test_random_traffic(21);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
